### hw/rtl/drb_pkg.sv
// ----------------------------------------------------------------------------
// drb_pkg
// Shared types and codes for the ring-buffer deque: mode codes, decoded
// operation word, result status codes and executor states.
// ----------------------------------------------------------------------------
package drb_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_COUNT_W = 5;
  localparam int MODE_W      = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_ADD_FRONT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_BACK     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_BACK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY        = 3'd5;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_REVERSE,
    OP_QUERY
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_RESULT
  } back_state_t;

  typedef struct packed {
    op_kind_t                kind;
    logic                    at_front;
    logic [IN_VALUE_W-1:0]   value;
  } drb_op_t;

endpackage

### hw/rtl/drb_front.sv
// ----------------------------------------------------------------------------
// drb_front
// Input side: takes words from the input port, decodes the mode into an
// operation kind and end select, and writes it into the operation queue.
// ----------------------------------------------------------------------------
module drb_front (
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [drb_pkg::MODE_W-1:0]        in_mode,
  input  logic [drb_pkg::IN_VALUE_W-1:0]    in_value,
  input  logic                              q_full,
  output logic                              q_wr,
  output drb_pkg::drb_op_t                  q_op
);

  assign in_full = q_full;
  assign q_wr    = in_push & ~q_full;

  always_comb begin
    q_op.value    = in_value;
    q_op.at_front = 1'b0;
    case (in_mode)
      drb_pkg::MODE_ADD_FRONT: begin
        q_op.kind     = drb_pkg::OP_ADD;
        q_op.at_front = 1'b1;
      end
      drb_pkg::MODE_ADD_BACK: begin
        q_op.kind = drb_pkg::OP_ADD;
      end
      drb_pkg::MODE_REMOVE_FRONT: begin
        q_op.kind     = drb_pkg::OP_REMOVE;
        q_op.at_front = 1'b1;
      end
      drb_pkg::MODE_REMOVE_BACK: begin
        q_op.kind = drb_pkg::OP_REMOVE;
      end
      drb_pkg::MODE_REVERSE: begin
        q_op.kind = drb_pkg::OP_REVERSE;
      end
      drb_pkg::MODE_QUERY: begin
        q_op.kind = drb_pkg::OP_QUERY;
      end
      default: begin
        q_op.kind = drb_pkg::OP_QUERY;
      end
    endcase
  end

endmodule

### hw/rtl/drb_fifo.sv
// ----------------------------------------------------------------------------
// drb_fifo
// Short operation queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module drb_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  drb_pkg::drb_op_t  wr_op,
  output logic              full,
  input  logic              rd_en,
  output logic              valid,
  output drb_pkg::drb_op_t  rd_op
);

  localparam int QAW = $clog2(drb_pkg::QUEUE_DEPTH);

  drb_pkg::drb_op_t mem_r [drb_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(drb_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign rd_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

### hw/rtl/drb_back.sv
// ----------------------------------------------------------------------------
// drb_back
// Executor: applies one operation to the ring buffer state, reads the end
// entries from the entry memory and loads the result register.
// ----------------------------------------------------------------------------
module drb_back #(
  parameter int DEPTH       = drb_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = drb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  drb_pkg::drb_op_t                   q_op,
  output logic                               q_rd,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [drb_pkg::OUT_VALUE_W-1:0]    out_front_value,
  output logic [drb_pkg::OUT_VALUE_W-1:0]    out_back_value,
  output logic [drb_pkg::OUT_COUNT_W-1:0]    out_count,
  output logic                               out_empty_res,
  output logic                               out_full_res,
  output logic [1:0]                         out_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  drb_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   rev_r, rev_nxt;
  drb_pkg::status_t       status_r, status_nxt;

  logic [VALUE_WIDTH-1:0] mem_r [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_front_r, rd_back_r;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [AW-1:0]          back_addr;

  logic                   start;
  logic                   load_out;
  logic                   is_full, is_empty, phys_front;
  logic [VALUE_WIDTH+drb_pkg::IN_VALUE_W-1:0] in_ext;

  logic [VALUE_WIDTH-1:0] pf, pb;
  logic [VALUE_WIDTH+drb_pkg::OUT_VALUE_W-1:0] pf_ext, pb_ext;
  logic [CW+drb_pkg::OUT_COUNT_W-1:0] cnt_ext;

  logic                              out_valid_r, out_valid_nxt;
  logic [drb_pkg::OUT_VALUE_W-1:0]   front_val_r, back_val_r;
  logic [drb_pkg::OUT_COUNT_W-1:0]   count_out_r;
  logic                              empty_res_r, full_res_r;
  logic [1:0]                        status_out_r;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      drb_pkg::BK_IDLE: begin
        if (q_valid && !out_valid_r) begin
          state_nxt = drb_pkg::BK_READ;
        end
      end
      drb_pkg::BK_READ: begin
        state_nxt = drb_pkg::BK_RESULT;
      end
      drb_pkg::BK_RESULT: begin
        state_nxt = drb_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = drb_pkg::BK_IDLE;
      end
    endcase
  end

  // state machine outputs
  always_comb begin
    start    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      drb_pkg::BK_IDLE: begin
        start = q_valid & ~out_valid_r;
      end
      drb_pkg::BK_RESULT: begin
        load_out = 1'b1;
      end
      default: begin
        start    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign q_rd = start;

  // operation execute
  assign is_full    = (count_r == CW'(DEPTH));
  assign is_empty   = (count_r == '0);
  assign phys_front = q_op.at_front ^ rev_r;
  assign in_ext     = {{VALUE_WIDTH{1'b0}}, q_op.value};
  assign wr_data    = in_ext[VALUE_WIDTH-1:0];

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = wrap_add(head_r, count_r[AW-1:0]);
    if (start) begin
      status_nxt = drb_pkg::ST_DONE;
      case (q_op.kind)
        drb_pkg::OP_ADD: begin
          if (is_full) begin
            status_nxt = drb_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (phys_front) begin
              head_nxt = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
              wr_addr  = head_nxt;
            end
          end
        end
        drb_pkg::OP_REMOVE: begin
          if (is_empty) begin
            status_nxt = drb_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            if (phys_front) begin
              head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
            end
          end
        end
        drb_pkg::OP_REVERSE: begin
          if (is_empty) begin
            status_nxt = drb_pkg::ST_EMPTY;
          end else begin
            rev_nxt = ~rev_r;
          end
        end
        default: begin
          status_nxt = drb_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign back_addr = wrap_add(head_r, AW'(count_r - 1'b1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_front_r <= mem_r[head_r];
    rd_back_r  <= mem_r[back_addr];
  end

  // result forming
  always_comb begin
    pf = is_empty ? '0 : rd_front_r;
    pb = is_empty ? '0 : rd_back_r;
    if (rev_r) begin
      pf = is_empty ? '0 : rd_back_r;
      pb = is_empty ? '0 : rd_front_r;
    end
    pf_ext  = {{drb_pkg::OUT_VALUE_W{1'b0}}, pf};
    pb_ext  = {{drb_pkg::OUT_VALUE_W{1'b0}}, pb};
    cnt_ext = {{drb_pkg::OUT_COUNT_W{1'b0}}, count_r};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drb_pkg::BK_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      status_r    <= drb_pkg::ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      front_val_r  <= pf_ext[drb_pkg::OUT_VALUE_W-1:0];
      back_val_r   <= pb_ext[drb_pkg::OUT_VALUE_W-1:0];
      count_out_r  <= cnt_ext[drb_pkg::OUT_COUNT_W-1:0];
      empty_res_r  <= is_empty;
      full_res_r   <= is_full;
      status_out_r <= status_r;
    end
  end

  assign out_empty       = ~out_valid_r;
  assign out_front_value = front_val_r;
  assign out_back_value  = back_val_r;
  assign out_count       = count_out_r;
  assign out_empty_res   = empty_res_r;
  assign out_full_res    = full_res_r;
  assign out_status      = status_out_r;

endmodule

### hw/rtl/deque_ring_buffer.sv
// ----------------------------------------------------------------------------
// deque_ring_buffer
// Double-ended queue in a ring buffer: decoder, operation queue and executor.
// ----------------------------------------------------------------------------
// result path: an input word is written into the operation queue; the executor
//   then updates the ring buffer state, does a registered read of both end
//   entries from the entry memory and loads the result register
// the executor takes no new word from the operation queue until the result
//   word of the last one has been taken
// reset: pointers, count, direction flag, operation queue and result valid
//   flag clear; entry memory and result fields are not cleared
module deque_ring_buffer #(
  parameter int DEPTH       = drb_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = drb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [drb_pkg::MODE_W-1:0]         in_mode,
  input  logic [drb_pkg::IN_VALUE_W-1:0]     in_value,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [drb_pkg::OUT_VALUE_W-1:0]    out_front_value,
  output logic [drb_pkg::OUT_VALUE_W-1:0]    out_back_value,
  output logic [drb_pkg::OUT_COUNT_W-1:0]    out_count,
  output logic                               out_empty_res,
  output logic                               out_full_res,
  output logic [1:0]                         out_status
);

  logic             q_full, q_wr, q_valid, q_rd;
  drb_pkg::drb_op_t wr_op, rd_op;

  drb_front u_front (
    .in_push  (in_push),
    .in_full  (in_full),
    .in_mode  (in_mode),
    .in_value (in_value),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_op     (wr_op)
  );

  drb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_wr),
    .wr_op (wr_op),
    .full  (q_full),
    .rd_en (q_rd),
    .valid (q_valid),
    .rd_op (rd_op)
  );

  drb_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (rd_op),
    .q_rd            (q_rd),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_empty_res   (out_empty_res),
    .out_full_res    (out_full_res),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_empty_res) |->
      (out_front_value == '0 && out_back_value == '0 && out_count == '0))
    else $error("empty result word carries nonzero fields");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_full_res && out_empty_res))
    else $error("result word both full and empty");

  a_status_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      ((out_status != 2'(drb_pkg::ST_FULL) || out_full_res) &&
       (out_status != 2'(drb_pkg::ST_EMPTY) || out_empty_res)))
    else $error("status disagrees with occupancy flags");
`endif

endmodule
